@@ rtl/core/fla_pkg.sv @@
// Shared types and constants for the free-list heap allocator.
// Used by the arithmetic unit, the header memory, the sequencer and the top level; no dependencies.
package fla_pkg;

    // request kinds
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // configuration register indexes
    localparam logic REG_HEAP = 1'b0;
    localparam logic REG_FIT  = 1'b1;

    // fixed field widths
    localparam int REQ_W      = 12;
    localparam int ADDR_W     = 12;
    localparam int CFG_HEAP_W = 13;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    // fit policies
    localparam logic FIT_FIRST = 1'b0;

    // shared arithmetic unit operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // header memory write strobes
    typedef struct packed {
        logic we_size;
        logic we_next;
    } t_mem_we;

endpackage

@@ rtl/core/fla_alu.sv @@
// Shared add/subtract unit with equal and unsigned greater-or-equal flags.
// Depends on fla_pkg for the operation type.
module fla_alu #(
    parameter int DW = 14
) (
    input  fla_pkg::t_alu_op i_op,
    input  logic [DW-1:0]    i_a,
    input  logic [DW-1:0]    i_b,
    output logic [DW-1:0]    o_res,
    output logic             o_eq,
    output logic             o_ge
);

    logic [DW-1:0] w_b;
    logic          w_cin;
    logic [DW:0]   w_sum;

    // one adder: subtract by inverting b and carrying in
    assign w_cin = (i_op == fla_pkg::ALU_SUB);
    assign w_b   = w_cin ? ~i_b : i_b;
    assign w_sum = {1'b0, i_a} + {1'b0, w_b} + {{DW{1'b0}}, w_cin};
    assign o_res = w_sum[DW-1:0];
    // flags are meaningful for a subtract
    assign o_ge  = w_sum[DW];
    assign o_eq  = (w_sum[DW-1:0] == '0);

endmodule

@@ rtl/core/fla_hdr_mem.sv @@
// Block header memory: one size and one next-link entry per aligned word.
// Separate write strobes for size and link, one registered read port; uses fla_pkg.
module fla_hdr_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int SW    = 13
) (
    input  logic             i_clk,
    input  fla_pkg::t_mem_we i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [SW-1:0]    i_wsize,
    input  logic [AW-1:0]    i_wnext,
    input  logic [AW-1:0]    i_raddr,
    output logic [SW-1:0]    o_rsize,
    output logic [AW-1:0]    o_rnext
);

    logic [SW-1:0] r_mem_size [DEPTH];
    logic [AW-1:0] r_mem_next [DEPTH];
    logic [SW-1:0] r_rsize;
    logic [AW-1:0] r_rnext;

    // write size and link independently
    always_ff @(posedge i_clk) begin
        if (i_we.we_size) begin
            r_mem_size[i_waddr] <= i_wsize;
        end
        if (i_we.we_next) begin
            r_mem_next[i_waddr] <= i_wnext;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rsize <= r_mem_size[i_raddr];
        r_rnext <= r_mem_next[i_raddr];
    end

    assign o_rsize = r_rsize;
    assign o_rnext = r_rnext;

endmodule

@@ rtl/core/fla_seq.sv @@
// Request sequencer: walks the free list one header per cycle, drives the
// shared arithmetic unit and the header memory, holds the result register. Uses fla_pkg.
module fla_seq #(
    parameter int HEAP_BYTES      = 4096,
    parameter int ALIGN_BYTES     = 8,
    parameter int MIN_BLOCK_BYTES = 16,
    localparam int LA        = $clog2(ALIGN_BYTES),
    localparam int DEPTH     = HEAP_BYTES / ALIGN_BYTES,
    localparam int AW        = $clog2(DEPTH),
    localparam int SW        = $clog2(HEAP_BYTES + 1),
    localparam int DW        = (SW + 2 > 14) ? SW + 2 : 14,
    localparam int MIN_TOTAL = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_init,
    input  logic [SW-1:0]              i_heap,
    input  logic                       i_fit,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_op,
    input  logic [fla_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [fla_pkg::ADDR_W-1:0] i_block_addr,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic [fla_pkg::ADDR_W-1:0] o_user_addr,
    output logic [fla_pkg::ADDR_W-1:0] o_usable_bytes,
    output fla_pkg::t_mem_we           o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [SW-1:0]              o_wsize,
    output logic [AW-1:0]              o_wnext,
    output logic [AW-1:0]              o_raddr,
    input  logic [SW-1:0]              i_rsize,
    input  logic [AW-1:0]              i_rnext,
    output fla_pkg::t_alu_op           o_alu_op,
    output logic [DW-1:0]              o_alu_a,
    output logic [DW-1:0]              o_alu_b,
    input  logic [DW-1:0]              i_alu_res,
    input  logic                       i_alu_eq,
    input  logic                       i_alu_ge
);

    localparam int NS = 23;

    typedef enum logic [NS-1:0] {
        S_CLR    = 23'b1 << 0,
        S_IDLE   = 23'b1 << 1,
        S_DONE   = 23'b1 << 2,
        S_A_HEAD = 23'b1 << 3,
        S_A_CHK  = 23'b1 << 4,
        S_A_REM  = 23'b1 << 5,
        S_A_SPL1 = 23'b1 << 6,
        S_A_SPL2 = 23'b1 << 7,
        S_A_LINK = 23'b1 << 8,
        S_B_ADDR = 23'b1 << 9,
        S_B_RNG  = 23'b1 << 10,
        S_F_RB   = 23'b1 << 11,
        S_F_WALK = 23'b1 << 12,
        S_F_NX   = 23'b1 << 13,
        S_F_MRG  = 23'b1 << 14,
        S_F_PV   = 23'b1 << 15,
        S_F_PWR  = 23'b1 << 16,
        S_F_WB   = 23'b1 << 17,
        S_F_LNK  = 23'b1 << 18,
        S_Q_RB   = 23'b1 << 19,
        S_Q_U    = 23'b1 << 20,
        S_Q_WALK = 23'b1 << 21,
        S_Q_ADD  = 23'b1 << 22
    } t_state;

    t_state r_state;

    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] r_head;
    logic          r_empty;

    logic [1:0]                 r_op;
    logic [DW-1:0]              r_total;
    logic [fla_pkg::ADDR_W-1:0] r_addr;
    logic [DW-1:0]              r_bbyte;

    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_prev;
    logic          r_hp;
    logic [SW-1:0] r_prev_sz;

    logic          r_found;
    logic [AW-1:0] r_pick;
    logic [SW-1:0] r_pick_sz;
    logic [AW-1:0] r_pick_next;
    logic [AW-1:0] r_pick_prev;
    logic          r_pick_hp;
    logic [SW-1:0] r_rem;
    logic [AW-1:0] r_sw;
    logic [AW-1:0] r_repl;

    logic [DW-1:0] r_sz;
    logic          r_has_cur;
    logic [SW-1:0] r_cur_sz;
    logic [AW-1:0] r_cur_next;
    logic [AW-1:0] r_nlink;

    logic [DW-1:0] r_end;
    logic [DW-1:0] r_u;

    logic                       r_res_status;
    logic [fla_pkg::ADDR_W-1:0] r_res_uaddr;
    logic [fla_pkg::ADDR_W-1:0] r_res_usable;

    logic                       r_ovalid;
    logic                       r_o_status;
    logic [fla_pkg::ADDR_W-1:0] r_o_uaddr;
    logic [fla_pkg::ADDR_W-1:0] r_o_usable;

    logic [AW-1:0] w_b;
    logic [DW-1:0] w_heap;
    logic [DW-1:0] w_mask;
    logic [DW-1:0] w_total_al;
    logic [DW-1:0] w_sw_sum;
    logic          w_better;
    logic          w_take;
    logic [SW-1:0] w_sat_res;
    logic [SW-1:0] w_sat_sz;
    logic          w_accept;
    logic          w_out_free;

    // byte offset of a header word
    function automatic logic [DW-1:0] f_byte(input logic [AW-1:0] w);
        f_byte = DW'({w, {LA{1'b0}}});
    endfunction

    assign w_b        = r_bbyte[LA +: AW];
    assign w_heap     = DW'(i_heap);
    assign w_mask     = ~DW'(ALIGN_BYTES - 1);
    assign w_total_al = i_alu_res & w_mask;
    assign w_sw_sum   = DW'(r_pick) + (r_total >> LA);
    assign w_better   = !r_found || (i_rsize < r_pick_sz);
    assign w_take     = i_alu_ge && w_better;
    assign w_sat_res  = (i_alu_res > w_heap) ? i_heap : i_alu_res[SW-1:0];
    assign w_sat_sz   = (r_sz > w_heap) ? i_heap : r_sz[SW-1:0];
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || !i_out_stall;

    // drive the shared unit for the current step
    always_comb begin
        o_alu_op = fla_pkg::ALU_SUB;
        o_alu_a  = '0;
        o_alu_b  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = DW'(i_request_bytes);
                o_alu_b  = DW'(2 * ALIGN_BYTES - 1);
            end
            S_B_ADDR: begin
                o_alu_a = DW'(r_addr);
                o_alu_b = DW'(ALIGN_BYTES);
            end
            S_B_RNG: begin
                o_alu_a = r_bbyte;
                o_alu_b = w_heap;
            end
            S_A_CHK: begin
                o_alu_a = DW'(i_rsize);
                o_alu_b = r_total;
            end
            S_A_REM: begin
                o_alu_a = DW'(r_pick_sz);
                o_alu_b = r_total;
            end
            S_A_LINK: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = f_byte(r_pick);
                o_alu_b  = DW'(ALIGN_BYTES);
            end
            S_F_NX: begin
                o_alu_a = f_byte(r_cur);
                o_alu_b = r_bbyte;
            end
            S_F_MRG: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = r_sz;
                o_alu_b  = DW'(r_cur_sz);
            end
            S_F_PV: begin
                o_alu_a = r_bbyte;
                o_alu_b = f_byte(r_prev);
            end
            S_F_PWR: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = DW'(r_prev_sz);
                o_alu_b  = r_sz;
            end
            S_Q_RB: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = r_bbyte;
                o_alu_b  = DW'(i_rsize);
            end
            S_Q_U: begin
                o_alu_a = r_sz;
                o_alu_b = DW'(ALIGN_BYTES);
            end
            S_Q_WALK: begin
                o_alu_a = f_byte(r_cur);
                o_alu_b = r_end;
            end
            S_Q_ADD: begin
                o_alu_op = fla_pkg::ALU_ADD;
                o_alu_a  = r_u;
                o_alu_b  = r_sz;
            end
            default: begin
                o_alu_op = fla_pkg::ALU_SUB;
            end
        endcase
    end

    // header read address: follow the link just read while walking
    always_comb begin
        unique case (r_state)
            S_A_HEAD, S_F_RB, S_Q_U:      o_raddr = r_head;
            S_B_RNG:                      o_raddr = w_b;
            S_A_CHK, S_F_WALK, S_Q_WALK:  o_raddr = i_rnext;
            default:                      o_raddr = r_cur;
        endcase
    end

    // header writes
    always_comb begin
        o_we    = '0;
        o_waddr = '0;
        o_wsize = '0;
        o_wnext = '0;
        unique case (r_state)
            S_CLR: begin
                o_we    = '{we_size: 1'b1, we_next: 1'b1};
                o_waddr = r_clr_idx;
                o_wsize = (r_clr_idx == '0) ? i_heap : '0;
            end
            S_A_SPL1: begin
                o_we    = '{we_size: 1'b1, we_next: 1'b1};
                o_waddr = r_sw;
                o_wsize = r_rem;
                o_wnext = r_pick_next;
            end
            S_A_SPL2: begin
                o_we.we_size = 1'b1;
                o_waddr      = r_pick;
                o_wsize      = r_total[SW-1:0];
            end
            S_A_LINK: begin
                o_we.we_next = r_pick_hp;
                o_waddr      = r_pick_prev;
                o_wnext      = r_repl;
            end
            S_F_RB: begin
                o_we.we_next = (i_rsize != '0) && r_empty;
                o_waddr      = w_b;
            end
            S_F_PWR: begin
                o_we    = '{we_size: 1'b1, we_next: 1'b1};
                o_waddr = r_prev;
                o_wsize = w_sat_res;
                o_wnext = r_nlink;
            end
            S_F_WB: begin
                o_we    = '{we_size: 1'b1, we_next: 1'b1};
                o_waddr = w_b;
                o_wsize = w_sat_sz;
                o_wnext = r_nlink;
            end
            S_F_LNK: begin
                o_we.we_next = 1'b1;
                o_waddr      = r_prev;
                o_wnext      = w_b;
            end
            default: begin
                o_we = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_head    <= '0;
            r_empty   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else if (i_init) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
        end else begin
            // drain the output register
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == AW'(DEPTH - 1)) begin
                        r_head  <= '0;
                        r_empty <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= i_op;
                        r_addr       <= i_block_addr;
                        r_total      <= (w_total_al < DW'(MIN_TOTAL)) ? DW'(MIN_TOTAL)
                                                                      : w_total_al;
                        r_res_status <= 1'b0;
                        r_res_uaddr  <= '0;
                        r_res_usable <= '0;
                        priority if (i_op == fla_pkg::OP_ALLOC) begin
                            r_state <= S_A_HEAD;
                        end else if (i_op == fla_pkg::OP_FREE || i_op == fla_pkg::OP_QUERY) begin
                            r_state <= S_B_ADDR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_uaddr  <= r_res_uaddr;
                        r_o_usable <= r_res_usable;
                        r_state    <= S_IDLE;
                    end
                end
                // allocate: walk from the head
                S_A_HEAD: begin
                    r_cur   <= r_head;
                    r_hp    <= 1'b0;
                    r_found <= 1'b0;
                    if (r_empty) begin
                        r_res_status <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_A_CHK;
                    end
                end
                S_A_CHK: begin
                    if (w_take) begin
                        r_found     <= 1'b1;
                        r_pick      <= r_cur;
                        r_pick_sz   <= i_rsize;
                        r_pick_next <= i_rnext;
                        r_pick_prev <= r_prev;
                        r_pick_hp   <= r_hp;
                    end
                    priority if (w_take && i_fit == fla_pkg::FIT_FIRST) begin
                        r_state <= S_A_REM;
                    end else if (i_rnext <= r_cur) begin
                        if (r_found || w_take) begin
                            r_state <= S_A_REM;
                        end else begin
                            r_res_status <= 1'b1;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_prev <= r_cur;
                        r_hp   <= 1'b1;
                        r_cur  <= i_rnext;
                    end
                end
                S_A_REM: begin
                    r_rem  <= i_alu_res[SW-1:0];
                    r_sw   <= w_sw_sum[AW-1:0];
                    r_repl <= r_pick_next;
                    if (i_alu_res >= DW'(MIN_TOTAL) && w_sw_sum < DW'(DEPTH)) begin
                        r_state <= S_A_SPL1;
                    end else begin
                        r_state <= S_A_LINK;
                    end
                end
                S_A_SPL1: begin
                    r_state <= S_A_SPL2;
                end
                S_A_SPL2: begin
                    r_repl  <= r_sw;
                    r_state <= S_A_LINK;
                end
                S_A_LINK: begin
                    if (!r_pick_hp) begin
                        if (r_repl == '0) begin
                            r_empty <= 1'b1;
                        end else begin
                            r_head <= r_repl;
                        end
                    end
                    r_res_uaddr <= i_alu_res[fla_pkg::ADDR_W-1:0];
                    r_state     <= S_DONE;
                end
                // free and query: locate the block header
                S_B_ADDR: begin
                    r_bbyte <= i_alu_res & w_mask;
                    r_state <= i_alu_ge ? S_B_RNG : S_DONE;
                end
                S_B_RNG: begin
                    priority if (i_alu_ge) begin
                        r_state <= S_DONE;
                    end else if (r_op == fla_pkg::OP_FREE) begin
                        r_state <= S_F_RB;
                    end else begin
                        r_state <= S_Q_RB;
                    end
                end
                // free
                S_F_RB: begin
                    r_sz  <= DW'(i_rsize);
                    r_cur <= r_head;
                    r_hp  <= 1'b0;
                    priority if (i_rsize == '0) begin
                        r_state <= S_DONE;
                    end else if (r_empty) begin
                        r_head  <= w_b;
                        r_empty <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_WALK;
                    end
                end
                S_F_WALK: begin
                    if (r_cur < w_b) begin
                        r_prev    <= r_cur;
                        r_prev_sz <= i_rsize;
                        r_hp      <= 1'b1;
                        if (i_rnext <= r_cur) begin
                            r_has_cur <= 1'b0;
                            r_state   <= S_F_NX;
                        end else begin
                            r_cur <= i_rnext;
                        end
                    end else begin
                        r_has_cur  <= 1'b1;
                        r_cur_sz   <= i_rsize;
                        r_cur_next <= i_rnext;
                        // double free: leave the list alone
                        r_state    <= (r_cur == w_b) ? S_DONE : S_F_NX;
                    end
                end
                S_F_NX: begin
                    if (!r_has_cur) begin
                        r_nlink <= '0;
                        r_state <= S_F_PV;
                    end else if (i_alu_res == r_sz) begin
                        r_nlink <= r_cur_next;
                        r_state <= S_F_MRG;
                    end else begin
                        r_nlink <= r_cur;
                        r_state <= S_F_PV;
                    end
                end
                S_F_MRG: begin
                    r_sz    <= i_alu_res;
                    r_state <= S_F_PV;
                end
                S_F_PV: begin
                    r_state <= (r_hp && i_alu_res == DW'(r_prev_sz)) ? S_F_PWR : S_F_WB;
                end
                S_F_PWR: begin
                    r_state <= S_DONE;
                end
                S_F_WB: begin
                    if (r_hp) begin
                        r_state <= S_F_LNK;
                    end else begin
                        r_head  <= w_b;
                        r_state <= S_DONE;
                    end
                end
                S_F_LNK: begin
                    r_state <= S_DONE;
                end
                // query
                S_Q_RB: begin
                    r_sz    <= DW'(i_rsize);
                    r_end   <= i_alu_res;
                    r_state <= S_Q_U;
                end
                S_Q_U: begin
                    r_u   <= i_alu_ge ? i_alu_res : '0;
                    r_cur <= r_head;
                    if (r_empty) begin
                        r_res_usable <= (i_alu_ge && i_alu_res > DW'(4095))
                                        ? '1 : (i_alu_ge ? i_alu_res[fla_pkg::ADDR_W-1:0] : '0);
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_Q_WALK;
                    end
                end
                S_Q_WALK: begin
                    priority if (i_alu_eq) begin
                        r_sz    <= DW'(i_rsize);
                        r_state <= S_Q_ADD;
                    end else if (i_alu_ge || i_rnext <= r_cur) begin
                        r_res_usable <= (r_u > DW'(4095)) ? '1 : r_u[fla_pkg::ADDR_W-1:0];
                        r_state      <= S_DONE;
                    end else begin
                        r_cur <= i_rnext;
                    end
                end
                S_Q_ADD: begin
                    r_res_usable <= (i_alu_res > DW'(4095)) ? '1
                                                            : i_alu_res[fla_pkg::ADDR_W-1:0];
                    r_state      <= S_DONE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_o_status;
    assign o_user_addr    = r_o_uaddr;
    assign o_usable_bytes = r_o_usable;

endmodule

@@ rtl/core/free_list_heap_allocator.sv @@
// Free-list heap allocator: address-ordered free list with first or best fit, block
// splitting and coalescing on free. Requests are handled one at a time; a request walks
// the free list reading one block header per cycle from the header memory (first fit
// stops at the first block that fits, best fit, free and size query walk up to
// HEAP_BYTES/MIN_BLOCK_BYTES blocks, 256 at the defaults). After reset and after each
// heap_bytes write the header memory is cleared, one word a cycle, HEAP_BYTES/ALIGN_BYTES
// words in all (512 at the defaults), during which no request is taken. The result
// register lets a new request start while the previous result waits. Depends on
// fla_pkg, fla_alu, fla_hdr_mem and fla_seq.
module free_list_heap_allocator #(
    parameter int HEAP_BYTES      = 4096,
    parameter int ALIGN_BYTES     = 8,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fla_pkg::CFG_AW-1:0]  paddr,
    input  logic [fla_pkg::CFG_DW-1:0]  pwdata,
    output logic [fla_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_op,
    input  logic [fla_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [fla_pkg::ADDR_W-1:0]  i_block_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_status,
    output logic [fla_pkg::ADDR_W-1:0]  o_user_addr,
    output logic [fla_pkg::ADDR_W-1:0]  o_usable_bytes
);

    localparam int DEPTH     = HEAP_BYTES / ALIGN_BYTES;
    localparam int AW        = $clog2(DEPTH);
    localparam int SW        = $clog2(HEAP_BYTES + 1);
    localparam int DW        = (SW + 2 > 14) ? SW + 2 : 14;
    localparam int CW        = (SW > fla_pkg::CFG_HEAP_W) ? SW : fla_pkg::CFG_HEAP_W;
    localparam int MIN_TOTAL = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int RST_HEAP  = (HEAP_BYTES < 4096) ? HEAP_BYTES : 4096;

    logic [SW-1:0] r_heap;
    logic          r_fit;
    logic          w_wr;
    logic [CW-1:0] w_val;
    logic [CW-1:0] w_clamp;

    fla_pkg::t_mem_we w_we;
    logic [AW-1:0]    w_waddr;
    logic [SW-1:0]    w_wsize;
    logic [AW-1:0]    w_wnext;
    logic [AW-1:0]    w_raddr;
    logic [SW-1:0]    w_rsize;
    logic [AW-1:0]    w_rnext;

    fla_pkg::t_alu_op w_alu_op;
    logic [DW-1:0]    w_alu_a;
    logic [DW-1:0]    w_alu_b;
    logic [DW-1:0]    w_alu_res;
    logic             w_alu_eq;
    logic             w_alu_ge;

    // configuration transaction
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // align down, then clamp into the supported heap range
    assign w_val   = CW'(pwdata[fla_pkg::CFG_HEAP_W-1:0]) & ~CW'(ALIGN_BYTES - 1);
    assign w_clamp = (w_val < CW'(MIN_TOTAL)) ? CW'(MIN_TOTAL)
                   : (w_val > CW'(HEAP_BYTES)) ? CW'(HEAP_BYTES) : w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= SW'(RST_HEAP);
            r_fit  <= fla_pkg::FIT_FIRST;
        end else if (w_wr) begin
            if (paddr[2] == fla_pkg::REG_HEAP) begin
                r_heap <= w_clamp[SW-1:0];
            end else begin
                r_fit <= pwdata[0];
            end
        end
    end

    // register readback
    always_comb begin
        if (paddr[2] == fla_pkg::REG_FIT) begin
            prdata = fla_pkg::CFG_DW'(r_fit);
        end else begin
            prdata = fla_pkg::CFG_DW'(r_heap);
        end
    end

    fla_alu #(
        .DW (DW)
    ) u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res),
        .o_eq  (w_alu_eq),
        .o_ge  (w_alu_ge)
    );

    fla_hdr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wsize (w_wsize),
        .i_wnext (w_wnext),
        .i_raddr (w_raddr),
        .o_rsize (w_rsize),
        .o_rnext (w_rnext)
    );

    fla_seq #(
        .HEAP_BYTES      (HEAP_BYTES),
        .ALIGN_BYTES     (ALIGN_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_init          (w_wr && paddr[2] == fla_pkg::REG_HEAP),
        .i_heap          (r_heap),
        .i_fit           (r_fit),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .i_block_addr    (i_block_addr),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_user_addr     (o_user_addr),
        .o_usable_bytes  (o_usable_bytes),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wsize         (w_wsize),
        .o_wnext         (w_wnext),
        .o_raddr         (w_raddr),
        .i_rsize         (w_rsize),
        .i_rnext         (w_rnext),
        .o_alu_op        (w_alu_op),
        .o_alu_a         (w_alu_a),
        .o_alu_b         (w_alu_b),
        .i_alu_res       (w_alu_res),
        .i_alu_eq        (w_alu_eq),
        .i_alu_ge        (w_alu_ge)
    );

endmodule
